// ===== src/slot_pool_allocator_assert.svh =====
// assertion macros for the slot pool allocator
`ifndef SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define SLOT_POOL_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/spa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

	localparam int SLOTS_DEFAULT = 256;

	localparam int OP_W      = 2;
	localparam int SLOT_W    = 8;
	localparam int COUNT_W   = 9;
	localparam int PRELOAD_W = 9;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// register index, taken from paddr above the byte offset
	localparam logic [APB_ADDR_W-3:0] REG_PRELOAD = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_INIT         = 2'd0,
		OP_CREATE       = 2'd1,
		OP_CREATE_LEVEL = 2'd2,
		OP_KILL         = 2'd3
	} spa_op_t;

endpackage

`default_nettype wire

// ===== src/slot_pool_allocator.sv =====
// Slot pool allocator: a pool of SLOTS slots handed out from a free list linked
// through one single-port-style memory whose words hold a slot's free-list link
// and its killed mark. One transaction is taken at a time and gives one result.
// Every step reads, modifies and writes back that memory, one access per cycle,
// so latency is set by the memory walk: create reads and rewrites the head slot's
// word (no memory access when the pool is empty), kill reads and rewrites the
// slot's word and then drops the high-water count past trailing killed slots (no
// memory access for a slot index out of range), and initialise rewrites every
// entry. After reset the block clears every memory entry with in_ready low;
// configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

`include "slot_pool_allocator_assert.svh"

module slot_pool_allocator #(
	parameter int SLOTS = spa_pkg::SLOTS_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [spa_pkg::OP_W-1:0]        operation,
	input  wire logic [spa_pkg::SLOT_W-1:0]      slot,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [spa_pkg::SLOT_W-1:0]      slot_out,
	output logic                                 slot_valid,
	output logic      [spa_pkg::COUNT_W-1:0]     total_count,
	output logic      [spa_pkg::COUNT_W-1:0]     level_count,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [spa_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [spa_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [spa_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready
);

	localparam int IW = $clog2(SLOTS);
	localparam int DW = $clog2(SLOTS + 1) + 1;

	logic [spa_pkg::PRELOAD_W-1:0] preload;
	logic                          ram_re;
	logic [IW-1:0]                 ram_raddr;
	logic [DW-1:0]                 ram_rdata;
	logic                          ram_we;
	logic [IW-1:0]                 ram_waddr;
	logic [DW-1:0]                 ram_wdata;

	spa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.preload (preload)
	);

	spa_ram #(
		.WIDTH (DW),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	spa_core #(
		.SLOTS (SLOTS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.slot        (slot),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.slot_out    (slot_out),
		.slot_valid  (slot_valid),
		.total_count (total_count),
		.level_count (level_count),
		.preload     (preload),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata)
	);

	// a read and a write never share a cycle, so no read-during-write hazard
	`ASSERT_IMPL(a_no_rw_overlap, clk, arst_n, ram_we, !ram_re)
	// one transaction in flight at a time
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_IMPL(a_wr_in_range, clk, arst_n, ram_we, (32'(ram_waddr) < 32'(SLOTS)))

endmodule

`default_nettype wire

// ===== src/spa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/spa_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spa_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [spa_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [spa_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [spa_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output logic      [spa_pkg::PRELOAD_W-1:0]   preload
);

	logic [spa_pkg::PRELOAD_W-1:0] preload_q;
	logic                          sel_preload;
	logic                          wr_en;

	assign pready      = 1'b1;
	assign sel_preload = (paddr[spa_pkg::APB_ADDR_W-1:2] == spa_pkg::REG_PRELOAD);
	assign wr_en       = psel && penable && pwrite && pready;
	assign prdata      = sel_preload ? spa_pkg::APB_DATA_W'(preload_q) : '0;
	assign preload     = preload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preload_q <= '0;
		end else if (wr_en && sel_preload) begin
			preload_q <= pwdata[spa_pkg::PRELOAD_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== src/spa_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spa_core #(
	parameter int SLOTS = spa_pkg::SLOTS_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [spa_pkg::OP_W-1:0]            operation,
	input  wire logic [spa_pkg::SLOT_W-1:0]          slot,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [spa_pkg::SLOT_W-1:0]          slot_out,
	output logic                                     slot_valid,
	output logic      [spa_pkg::COUNT_W-1:0]         total_count,
	output logic      [spa_pkg::COUNT_W-1:0]         level_count,
	input  wire logic [spa_pkg::PRELOAD_W-1:0]       preload,
	output logic                                     ram_re,
	output logic      [$clog2(SLOTS)-1:0]            ram_raddr,
	input  wire logic [$clog2(SLOTS+1):0]            ram_rdata,
	output logic                                     ram_we,
	output logic      [$clog2(SLOTS)-1:0]            ram_waddr,
	output logic      [$clog2(SLOTS+1):0]            ram_wdata
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST    = IW'(SLOTS - 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_CRT_RD,
		S_CRT_WR,
		S_KILL_RD,
		S_KILL_WR,
		S_SHR_RD,
		S_SHR_CHK,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                head_q;
	logic [CW-1:0]                hw_q;
	logic [CW-1:0]                prot_q;
	logic [IW-1:0]                idx_q;
	logic [IW-1:0]                kslot_q;
	logic                         lvl_q;
	logic [spa_pkg::SLOT_W-1:0]   res_slot_q;
	logic                         res_valid_q;
	logic                         out_valid_q;
	logic [spa_pkg::SLOT_W-1:0]   slot_out_q;
	logic                         slot_valid_q;
	logic [spa_pkg::COUNT_W-1:0]  total_q;
	logic [spa_pkg::COUNT_W-1:0]  level_q;

	logic [CW-1:0] preload_clamp;
	logic          kill_push;
	logic [CW-1:0] rd_next;
	logic          rd_killed;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign slot_out    = slot_out_q;
	assign slot_valid  = slot_valid_q;
	assign total_count = total_q;
	assign level_count = level_q;

	assign preload_clamp = (32'(preload) > 32'(SLOTS)) ? SLOTS_C : CW'(preload);
	assign kill_push     = (CW'(kslot_q) >= prot_q);
	assign rd_next       = ram_rdata[CW-1:0];
	assign rd_killed     = ram_rdata[CW];

	// memory word: killed mark on top, free-list link below
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = kslot_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = {1'b0, CW'(idx_q) + CW'(1)};
			end
			S_CRT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = IW'(head_q);
			end
			S_CRT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = IW'(head_q);
				ram_wdata = {1'b0, rd_next};
			end
			S_KILL_RD: begin
				ram_re = 1'b1;
			end
			S_KILL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = kslot_q;
				ram_wdata = {1'b1, kill_push ? head_q : rd_next};
			end
			S_SHR_RD: begin
				ram_re    = (hw_q != '0);
				ram_raddr = IW'(hw_q - CW'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			head_q       <= SLOTS_C;
			hw_q         <= '0;
			prot_q       <= '0;
			idx_q        <= '0;
			kslot_q      <= '0;
			lvl_q        <= 1'b0;
			res_slot_q   <= '0;
			res_valid_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			slot_out_q   <= '0;
			slot_valid_q <= 1'b0;
			total_q      <= '0;
			level_q      <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == LAST) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						res_slot_q  <= '0;
						res_valid_q <= 1'b0;
						unique case (spa_pkg::spa_op_t'(operation))
							spa_pkg::OP_INIT: begin
								prot_q  <= preload_clamp;
								hw_q    <= preload_clamp;
								head_q  <= preload_clamp;
								idx_q   <= '0;
								state_q <= S_INIT;
							end
							spa_pkg::OP_CREATE, spa_pkg::OP_CREATE_LEVEL: begin
								lvl_q <= (spa_pkg::spa_op_t'(operation)
									== spa_pkg::OP_CREATE_LEVEL);
								state_q <= (head_q >= SLOTS_C) ? S_DONE : S_CRT_RD;
							end
							spa_pkg::OP_KILL: begin
								kslot_q <= IW'(slot);
								state_q <= (32'(slot) < 32'(SLOTS)) ? S_KILL_RD : S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INIT: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == LAST) begin
						idx_q   <= '0;
						state_q <= S_DONE;
					end
				end
				S_CRT_RD: begin
					state_q <= S_CRT_WR;
				end
				S_CRT_WR: begin
					head_q      <= rd_next;
					res_slot_q  <= spa_pkg::SLOT_W'(head_q);
					res_valid_q <= 1'b1;
					if (head_q + CW'(1) > hw_q) begin
						hw_q <= head_q + CW'(1);
					end
					if (lvl_q && (prot_q < SLOTS_C)) begin
						prot_q <= prot_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_KILL_RD: begin
					state_q <= S_KILL_WR;
				end
				S_KILL_WR: begin
					if (kill_push) begin
						head_q <= CW'(kslot_q);
					end
					state_q <= S_SHR_RD;
				end
				// trailing killed slots drop off the high-water count
				S_SHR_RD: begin
					state_q <= (hw_q == '0) ? S_DONE : S_SHR_CHK;
				end
				S_SHR_CHK: begin
					if (rd_killed) begin
						hw_q    <= hw_q - CW'(1);
						state_q <= S_SHR_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						slot_out_q   <= res_slot_q;
						slot_valid_q <= res_valid_q;
						total_q      <= spa_pkg::COUNT_W'(hw_q);
						level_q      <= spa_pkg::COUNT_W'(prot_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== verif/slot_pool_allocator_tb.sv =====
`timescale 1ns / 1ps

module slot_pool_allocator_tb;

	localparam int POOL = spa_pkg::SLOTS_DEFAULT;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 600;

	typedef struct packed {
		spa_pkg::spa_op_t           op;
		logic [spa_pkg::SLOT_W-1:0] slot;
	} pool_req_t;

	typedef struct packed {
		logic [spa_pkg::SLOT_W-1:0]  slot_out;
		logic                        slot_valid;
		logic [spa_pkg::COUNT_W-1:0] total_count;
		logic [spa_pkg::COUNT_W-1:0] level_count;
	} pool_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [spa_pkg::OP_W-1:0]         operation = '0;
	logic [spa_pkg::SLOT_W-1:0]       slot = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic [spa_pkg::SLOT_W-1:0]       slot_out;
	logic                             slot_valid;
	logic [spa_pkg::COUNT_W-1:0]      total_count;
	logic [spa_pkg::COUNT_W-1:0]      level_count;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [spa_pkg::APB_ADDR_W-1:0]   paddr = '0;
	logic [spa_pkg::APB_DATA_W-1:0]   pwdata = '0;
	logic [spa_pkg::APB_DATA_W-1:0]   prdata;
	logic                             pready;

	// predictor state
	logic [spa_pkg::COUNT_W-1:0]   free_link [POOL];
	logic                          dead_flag [POOL];
	logic                          slot_held [POOL];
	logic [spa_pkg::COUNT_W-1:0]   head_slot = spa_pkg::COUNT_W'(POOL);
	logic [spa_pkg::COUNT_W-1:0]   hwm_count = '0;
	logic [spa_pkg::COUNT_W-1:0]   prot_count = '0;
	logic [spa_pkg::PRELOAD_W-1:0] preload_reg = '0;

	pool_req_t    pending_ops [$];
	pool_result_t expected_pool_results [$];
	pool_req_t    next_req;
	pool_result_t want_result;

	int queued_total = 0;
	int accepted_total = 0;
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int create_pct = 60;
	logic rx_hold = 1'b0;
	event rx_hold_go;
	int preload_plan [8] = '{0, 200, 256, 5, 511, 240, 64, 0};

	slot_pool_allocator dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < POOL; i++) begin
			dead_flag[i] = 1'b0;
			slot_held[i] = 1'b0;
		end
	end

	function automatic pool_result_t apply_pool_op(input spa_pkg::spa_op_t op,
		input logic [spa_pkg::SLOT_W-1:0] s);
		pool_result_t r;
		logic [spa_pkg::COUNT_W-1:0] p;
		logic [spa_pkg::COUNT_W-1:0] h;
		r = '0;
		case (op)
			spa_pkg::OP_INIT: begin
				p = (preload_reg > POOL) ? spa_pkg::COUNT_W'(POOL)
					: spa_pkg::COUNT_W'(preload_reg);
				prot_count = p;
				hwm_count = p;
				head_slot = p;
				for (int i = 0; i < POOL; i++) begin
					if (i >= p && i + 1 < POOL)
						free_link[i] = spa_pkg::COUNT_W'(i + 1);
					dead_flag[i] = 1'b0;
					slot_held[i] = (i < p);
				end
				free_link[POOL-1] = spa_pkg::COUNT_W'(POOL);
			end
			spa_pkg::OP_CREATE, spa_pkg::OP_CREATE_LEVEL: begin
				h = head_slot;
				if (h < POOL) begin
					dead_flag[h] = 1'b0;
					slot_held[h] = 1'b1;
					head_slot = free_link[h];
					if (h + 1 > hwm_count)
						hwm_count = spa_pkg::COUNT_W'(h + 1);
					r.slot_out = h[spa_pkg::SLOT_W-1:0];
					r.slot_valid = 1'b1;
					if (op == spa_pkg::OP_CREATE_LEVEL && prot_count < POOL)
						prot_count = spa_pkg::COUNT_W'(prot_count + 1);
				end
			end
			default: begin
				dead_flag[s] = 1'b1;
				slot_held[s] = 1'b0;
				if (s >= prot_count) begin
					free_link[s] = head_slot;
					head_slot = spa_pkg::COUNT_W'(s);
				end
				while (hwm_count > 0 && dead_flag[hwm_count - 1])
					hwm_count = spa_pkg::COUNT_W'(hwm_count - 1);
			end
		endcase
		r.total_count = hwm_count;
		r.level_count = prot_count;
		return r;
	endfunction

	// rare initialises, creates at create_pct, else mostly kills of slots in use, some kills of anything
	function automatic pool_req_t random_req();
		pool_req_t q;
		int r;
		int start;
		int idx;
		logic found;
		r = int'($urandom_range(99));
		q.slot = spa_pkg::SLOT_W'($urandom);
		found = 1'b0;
		if (r < 1) begin
			q.op = spa_pkg::OP_INIT;
		end else if (r < create_pct) begin
			q.op = ($urandom_range(3) == 0) ? spa_pkg::OP_CREATE_LEVEL : spa_pkg::OP_CREATE;
		end else begin
			q.op = spa_pkg::OP_KILL;
			if ($urandom_range(9) != 0) begin
				start = int'($urandom_range(POOL - 1));
				for (int k = 0; k < POOL && !found; k++) begin
					idx = (start + k) % POOL;
					if (slot_held[idx]) begin
						q.slot = spa_pkg::SLOT_W'(idx);
						found = 1'b1;
					end
				end
			end
		end
		return q;
	endfunction

	task automatic queue_req(input spa_pkg::spa_op_t op, input logic [spa_pkg::SLOT_W-1:0] s);
		pool_req_t q;
		q.op = op;
		q.slot = s;
		while (pending_ops.size() >= 2)
			@(posedge clk);
		pending_ops.push_back(q);
		queued_total++;
	endtask

	task automatic drain();
		while (accepted_total != queued_total || expected_pool_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_preload(input logic [spa_pkg::PRELOAD_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {spa_pkg::REG_PRELOAD, 2'b00};
		pwdata <= spa_pkg::APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		preload_reg = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[spa_pkg::PRELOAD_W-1:0] !== value) begin
			$error("preload_count expected %0d got %0d", value,
				prdata[spa_pkg::PRELOAD_W-1:0]);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_pool_results.push_back(
					apply_pool_op(spa_pkg::spa_op_t'(operation), slot));
				accepted_total++;
			end
			if (!in_valid || in_ready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_ops.pop_front();
					in_valid <= 1'b1;
					operation <= next_req.op;
					slot <= next_req.slot;
				end else begin
					in_valid <= 1'b0;
					operation <= spa_pkg::OP_W'($urandom);
					slot <= spa_pkg::SLOT_W'($urandom);
				end
			end
		end
	end

	// long receiver hold-off
	always begin
		@(rx_hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_pool_results.size() == 0) begin
					$error("unexpected transaction: slot_out %0d total_count %0d",
						slot_out, total_count);
					mismatch_count++;
				end else begin
					want_result = expected_pool_results.pop_front();
					if (slot_out !== want_result.slot_out) begin
						$error("slot_out expected %0d got %0d", want_result.slot_out, slot_out);
						mismatch_count++;
					end
					if (slot_valid !== want_result.slot_valid) begin
						$error("slot_valid expected %0d got %0d",
							want_result.slot_valid, slot_valid);
						mismatch_count++;
					end
					if (total_count !== want_result.total_count) begin
						$error("total_count expected %0d got %0d",
							want_result.total_count, total_count);
						mismatch_count++;
					end
					if (level_count !== want_result.level_count) begin
						$error("level_count expected %0d got %0d",
							want_result.level_count, level_count);
						mismatch_count++;
					end
				end
			end
			out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		pool_req_t q;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty pool before any initialise, kill and reuse, double kill
		queue_req(spa_pkg::OP_CREATE, 8'd0);
		queue_req(spa_pkg::OP_KILL, 8'd255);
		queue_req(spa_pkg::OP_CREATE, 8'd0);
		queue_req(spa_pkg::OP_KILL, 8'd255);
		queue_req(spa_pkg::OP_INIT, 8'd0);
		queue_req(spa_pkg::OP_CREATE, 8'd0);
		queue_req(spa_pkg::OP_CREATE_LEVEL, 8'd0);
		queue_req(spa_pkg::OP_KILL, 8'd0);
		queue_req(spa_pkg::OP_KILL, 8'd1);
		queue_req(spa_pkg::OP_KILL, 8'd1);
		queue_req(spa_pkg::OP_CREATE, 8'd0);
		queue_req(spa_pkg::OP_CREATE, 8'd0);
		drain();

		// level count saturation through a self-linked slot
		write_preload(9'd254);
		queue_req(spa_pkg::OP_INIT, 8'd0);
		queue_req(spa_pkg::OP_CREATE_LEVEL, 8'd0);
		queue_req(spa_pkg::OP_KILL, 8'd255);
		queue_req(spa_pkg::OP_CREATE_LEVEL, 8'd0);
		queue_req(spa_pkg::OP_CREATE_LEVEL, 8'd0);
		queue_req(spa_pkg::OP_KILL, 8'd254);
		drain();

		// preload above pool size
		write_preload(9'd511);
		queue_req(spa_pkg::OP_INIT, 8'd0);
		queue_req(spa_pkg::OP_CREATE, 8'd0);
		queue_req(spa_pkg::OP_CREATE_LEVEL, 8'd0);
		queue_req(spa_pkg::OP_KILL, 8'd0);
		queue_req(spa_pkg::OP_KILL, 8'd255);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 77;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 77;
				end
				default: begin
					send_idle_pct = 18;
					recv_stall_pct = 18;
				end
			endcase
			write_preload((ph == 7) ? spa_pkg::PRELOAD_W'($urandom_range(300))
				: spa_pkg::PRELOAD_W'(preload_plan[ph]));
			queue_req(spa_pkg::OP_INIT, spa_pkg::SLOT_W'($urandom));
			for (int n = 0; n < 150; n++) begin
				if (n % 25 == 0)
					create_pct = ($urandom_range(1) == 0) ? 80 : 25;
				if (ph == 1 && n == 40)
					-> rx_hold_go;
				if (ph == 4 && n == 75)
					drain();
				q = random_req();
				queue_req(q.op, q.slot);
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
